>>> rtl/vad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_pkg
// shared types and constants for the vector angle pipeline
// ----------------------------------------------------------------------------
package vad_pkg;

  // guard bits appended below the magnitudes in the cordic datapath
  localparam int GUARD_BITS = 24;
  // number of arctangent entries, also the largest usable stage count
  localparam int TAB_LEN    = 24;
  // angle accumulator width and its fraction bits below the q9.7 lsb
  localparam int Z_W        = 24;
  localparam int Z_FRAC     = 8;
  // result width
  localparam int ANGLE_W    = 16;

  // quarter turn in accumulator units, and the folding constants in q9.7
  localparam logic signed [Z_W-1:0] RIGHT_Z     = 24'sd2947933;
  localparam logic [ANGLE_W-1:0]    RIGHT_Q     = 16'd11515;
  localparam logic [ANGLE_W-1:0]    HALF_TURN_Q = 16'd23040;
  localparam logic [ANGLE_W-1:0]    FULL_TURN_Q = 16'd46080;

  // atan(2^-i) in degrees (22/7 scale) times 2^15, rounded
  localparam logic signed [Z_W-1:0] ATAN_TAB [TAB_LEN] = '{
    24'sd1473967, 24'sd870133, 24'sd459755, 24'sd233379,
    24'sd117142,  24'sd58628,  24'sd29321,  24'sd14662,
    24'sd7331,    24'sd3665,   24'sd1833,   24'sd916,
    24'sd458,     24'sd229,    24'sd115,    24'sd57,
    24'sd29,      24'sd14,     24'sd7,      24'sd4,
    24'sd2,       24'sd1,      24'sd0,      24'sd0
  };

  // sign and zero information of the input vector, carried down the pipe
  typedef struct packed {
    logic dx_neg;
    logic dx_zero;
    logic dy_neg;
    logic dy_zero;
  } vad_flags_t;

endpackage

>>> rtl/vad_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_prep
// input stage: magnitudes, guard bits and sign/zero flags
// ----------------------------------------------------------------------------
module vad_prep #(
  parameter int COORD_WIDTH = 16,
  parameter int XY_W        = 43
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [COORD_WIDTH-1:0]     dx_i,
  input  logic signed [COORD_WIDTH-1:0]     dy_i,
  output logic                              valid_o,
  output logic signed [XY_W-1:0]            x_o,
  output logic signed [XY_W-1:0]            y_o,
  output vad_pkg::vad_flags_t               flags_o
);
  import vad_pkg::*;

  logic [COORD_WIDTH-1:0]  ax, ay;
  logic signed [XY_W-1:0]  x_d, y_d, x_q, y_q;
  vad_flags_t              flags_d, flags_q;
  logic                    valid_q;

  always_comb begin
    ax = dx_i[COORD_WIDTH-1] ? COORD_WIDTH'(-dx_i) : COORD_WIDTH'(dx_i);
    ay = dy_i[COORD_WIDTH-1] ? COORD_WIDTH'(-dy_i) : COORD_WIDTH'(dy_i);
    // |dy| feeds the x channel, |dx| the y channel
    x_d = $signed(XY_W'({ay, {GUARD_BITS{1'b0}}}));
    y_d = $signed(XY_W'({ax, {GUARD_BITS{1'b0}}}));
    flags_d.dx_neg  = dx_i[COORD_WIDTH-1];
    flags_d.dx_zero = (dx_i == '0);
    flags_d.dy_neg  = dy_i[COORD_WIDTH-1];
    flags_d.dy_zero = (dy_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    flags_q <= flags_d;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign flags_o = flags_q;

endmodule

>>> rtl/vad_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_cordic_stage
// one registered vectoring micro-rotation with a fixed shift
// ----------------------------------------------------------------------------
module vad_cordic_stage #(
  parameter int XY_W  = 43,
  parameter int SHIFT = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic signed [XY_W-1:0]               x_i,
  input  logic signed [XY_W-1:0]               y_i,
  input  logic signed [vad_pkg::Z_W-1:0]       z_i,
  input  vad_pkg::vad_flags_t                  flags_i,
  output logic                                 valid_o,
  output logic signed [XY_W-1:0]               x_o,
  output logic signed [XY_W-1:0]               y_o,
  output logic signed [vad_pkg::Z_W-1:0]       z_o,
  output vad_pkg::vad_flags_t                  flags_o
);
  import vad_pkg::*;

  localparam logic [XY_W-1:0]        LOW_MASK = ~({XY_W{1'b1}} << SHIFT);
  localparam logic signed [Z_W-1:0]  ATAN_I   = ATAN_TAB[SHIFT];

  logic                    y_neg, trunc_c;
  logic signed [XY_W-1:0]  xs, ys_fl;
  logic signed [XY_W-1:0]  x_d, y_d, x_q, y_q;
  logic signed [Z_W-1:0]   z_d, z_q;
  vad_flags_t              flags_q;
  logic                    valid_q;

  always_comb begin
    y_neg = y_i[XY_W-1];
    // x never goes negative, so the arithmetic shift already truncates toward zero
    xs    = x_i >>> SHIFT;
    ys_fl = y_i >>> SHIFT;
    // a negative y shifted toward zero is one above the floor when bits drop out
    trunc_c = y_neg & (|(y_i & LOW_MASK));
    if (y_neg) begin
      x_d = x_i - ys_fl - XY_W'(trunc_c);
      y_d = y_i + xs;
      z_d = z_i - ATAN_I;
    end else begin
      x_d = x_i + ys_fl;
      y_d = y_i - xs;
      z_d = z_i + ATAN_I;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    flags_q <= flags_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign flags_o = flags_q;

endmodule

>>> rtl/vad_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_fold
// clamp and round the base angle, then fold it onto the full circle
// ----------------------------------------------------------------------------
module vad_fold (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [vad_pkg::Z_W-1:0]     z_i,
  input  vad_pkg::vad_flags_t                flags_i,
  output logic                               valid_o,
  output logic [vad_pkg::ANGLE_W-1:0]        angle_o
);
  import vad_pkg::*;

  logic signed [Z_W-1:0]  zc, zsum;
  logic [ANGLE_W-1:0]     a_d, a_q;
  vad_flags_t             flags_q;
  logic                   va_q;
  logic                   dx_le0, dx_ge0, dy_le0, dy_ge0;
  logic [ANGLE_W-1:0]     r_d, r_q;
  logic                   vr_q;

  // first half: clamp to a quarter turn, round to nearest, force a quarter turn when dy is zero
  always_comb begin
    priority if (z_i < 0) begin
      zc = '0;
    end else if (z_i > RIGHT_Z) begin
      zc = RIGHT_Z;
    end else begin
      zc = z_i;
    end
    zsum = zc + Z_W'(1 << (Z_FRAC - 1));
    if (flags_i.dy_zero) begin
      a_d = RIGHT_Q;
    end else begin
      a_d = ANGLE_W'(zsum[Z_W-1:Z_FRAC]);
    end
  end

  // second half: quadrant fold, first matching rule wins
  always_comb begin
    dx_le0 = flags_q.dx_neg | flags_q.dx_zero;
    dx_ge0 = ~flags_q.dx_neg;
    dy_le0 = flags_q.dy_neg | flags_q.dy_zero;
    dy_ge0 = ~flags_q.dy_neg;
    priority if (flags_q.dx_zero && flags_q.dy_zero) begin
      r_d = '0;
    end else if (dx_le0 && dy_ge0) begin
      r_d = FULL_TURN_Q - a_q;
    end else if (dx_le0 && dy_le0) begin
      r_d = HALF_TURN_Q + a_q;
    end else if (dx_ge0 && dy_le0) begin
      r_d = HALF_TURN_Q - a_q;
    end else begin
      r_d = a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vr_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vr_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    flags_q <= flags_i;
    r_q     <= r_d;
  end

  assign valid_o = vr_q;
  assign angle_o = r_q;

endmodule

>>> rtl/vector_angle_degrees.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angle_degrees
// direction of a displacement vector in degrees, pipelined vectoring cordic
// ----------------------------------------------------------------------------
// The block takes one vector (dx_i, dy_i) in every clock cycle: a transfer
// happens when start_i is high, and busy_o stays low, so the block never
// refuses one. Each transfer gives exactly one result, shown on angle_q_o for
// a single cycle with done_o high. The pipe is one input stage, one register
// per micro-rotation (CORDIC_STAGES of them, a count above 24 acting as 24)
// and two output stages; the sustained rate is one result per cycle. There
// is no backpressure on the result side: whoever watches done_o has to take
// the result in that cycle.
// The angle is unsigned q9.7 degrees on a 22/7 pi scale, 0 to 360.
// ----------------------------------------------------------------------------
module vector_angle_degrees #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [COORD_WIDTH-1:0]      dx_i,
  input  logic signed [COORD_WIDTH-1:0]      dy_i,
  output logic                               done_o,
  output logic [vad_pkg::ANGLE_W-1:0]        angle_q_o
);
  import vad_pkg::*;

  // micro-rotations actually built, capped by the arctangent table
  localparam int N_EFF = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
  // datapath width: magnitude, guard bits, cordic gain and sign
  localparam int XY_W  = COORD_WIDTH + GUARD_BITS + 3;
  // cycles from a transfer to its result strobe
  localparam int LAT   = N_EFF + 3;

  logic                    take;
  logic                    v_s   [N_EFF+1];
  logic signed [XY_W-1:0]  x_s   [N_EFF+1];
  logic signed [XY_W-1:0]  y_s   [N_EFF+1];
  logic signed [Z_W-1:0]   z_s   [N_EFF+1];
  vad_flags_t              f_s   [N_EFF+1];

  // fully pipelined, so nothing ever holds the input off
  assign busy_o = 1'b0;
  assign take   = start_i & ~busy_o;

  // magnitudes and flags
  vad_prep #(
    .COORD_WIDTH (COORD_WIDTH),
    .XY_W        (XY_W)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (take),
    .dx_i    (dx_i),
    .dy_i    (dy_i),
    .valid_o (v_s[0]),
    .x_o     (x_s[0]),
    .y_o     (y_s[0]),
    .flags_o (f_s[0])
  );

  // angle accumulator starts from zero
  assign z_s[0] = '0;

  // one register stage per micro-rotation
  for (genvar i = 0; i < N_EFF; i++) begin : g_rot
    vad_cordic_stage #(
      .XY_W  (XY_W),
      .SHIFT (i)
    ) u_rot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_s[i]),
      .x_i     (x_s[i]),
      .y_i     (y_s[i]),
      .z_i     (z_s[i]),
      .flags_i (f_s[i]),
      .valid_o (v_s[i+1]),
      .x_o     (x_s[i+1]),
      .y_o     (y_s[i+1]),
      .z_o     (z_s[i+1]),
      .flags_o (f_s[i+1])
    );
  end

  // rounding, special cases and quadrant fold
  vad_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_s[N_EFF]),
    .z_i     (z_s[N_EFF]),
    .flags_i (f_s[N_EFF]),
    .valid_o (done_o),
    .angle_o (angle_q_o)
  );

  // every transfer comes out after exactly the pipe latency
  a_take_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##LAT done_o)
    else $error("transfer did not produce a result");

  // no result without a transfer that long ago
  a_done_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(take, LAT))
    else $error("result strobe without a matching transfer");

  // folded angle stays within one full turn
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (angle_q_o <= FULL_TURN_Q))
    else $error("angle beyond a full turn");

  // zero vector answers zero
  a_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(dx_i, LAT) == '0) && ($past(dy_i, LAT) == '0))
      |-> (angle_q_o == '0))
    else $error("zero vector gave a nonzero angle");

endmodule
